FILE: rtl/rpmf_pkg.sv
// Shared types and constants for the running row mean block.
`timescale 1ns / 1ps

package rpmf_pkg;

  localparam int SUM_W    = 32;
  localparam int COLUMN_BITS = 16;
  localparam int DIV_W    = COLUMN_BITS + 1;
  localparam int RW_W     = 16;
  localparam int CNT_W    = $clog2(SUM_W);
  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 16'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } dp_cmd_t;

endpackage

FILE: rtl/rpmf_ctrl.sv
// Controller: sequences loading, divider iterations and the result handoff.
`timescale 1ns / 1ps

module rpmf_ctrl
  import rpmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // The finished item moves to the output register once it is free.
        if (!out_valid_r || out_tready) begin
          cmd.fix       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/rpmf_dp.sv
// Datapath: row sum, column, row width register and restoring floor divider.
`timescale 1ns / 1ps

module rpmf_dp
  import rpmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic             cfg_wr_en,
  input  logic [RW_W-1:0]  cfg_wr_data,
  input  logic [SUM_W-1:0] sample,
  output logic [SUM_W-1:0] mean
);

  logic [RW_W-1:0]        row_width_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [COLUMN_BITS-1:0] column_r, column_nxt;
  logic [DIV_W-1:0]       next_pos;
  logic                   row_end;
  logic [SUM_W-1:0]       new_sum;

  logic                   neg_r;
  logic [DIV_W-1:0]       den_r;
  logic [DIV_W-1:0]       rem_r;
  logic [SUM_W-1:0]       quo_r;
  logic [SUM_W-1:0]       mean_r;

  logic [DIV_W:0]         rem_shift;
  logic [DIV_W:0]         diff;

  assign new_sum  = sum_r + sample;
  assign next_pos = {1'b0, column_r} + 1'b1;
  assign row_end  = (32'(next_pos) >= 32'(row_width_r)) || (column_r == '1);

  always_comb begin
    sum_nxt    = sum_r;
    column_nxt = column_r;
    if (cmd.load) begin
      if (row_end) begin
        sum_nxt    = '0;
        column_nxt = '0;
      end else begin
        sum_nxt    = new_sum;
        column_nxt = next_pos[COLUMN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
      sum_r       <= '0;
      column_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_width_r <= cfg_wr_data;
      end
      sum_r    <= sum_nxt;
      column_r <= column_nxt;
    end
  end

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign diff      = rem_shift - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= new_sum[SUM_W-1];
      den_r <= next_pos;
      rem_r <= '0;
      quo_r <= new_sum[SUM_W-1] ? (~new_sum + 1'b1) : new_sum;
    end else if (cmd.step) begin
      if (!diff[DIV_W]) begin
        rem_r <= diff[DIV_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_shift[DIV_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      // Floor of a negative quotient: -(q + 1) = ~q when a remainder is left.
      if (!neg_r) begin
        mean_r <= quo_r;
      end else if (rem_r != '0) begin
        mean_r <= ~quo_r;
      end else begin
        mean_r <= ~quo_r + 1'b1;
      end
    end
  end

  assign mean = mean_r;

endmodule

FILE: rtl/row_prefix_mean_floor_core.sv
// Top level of the running row mean block.
`timescale 1ns / 1ps

// Takes signed 32-bit samples and, for each one, returns the floor of the
// wrapped running row sum divided by the sample's column plus one. The row
// restarts after row_width samples (reset value 1024), set through the
// cfg_wr_en / cfg_wr_data port; the user is to write it only while the block
// is idle, which the block does not enforce. The sum and column update at the
// edge that accepts an item. The result lands in the output register after
// 32 restoring divider iterations, one quotient bit per cycle, and a floor
// correction once it is free; no new item is taken before then. The next item
// is accepted while a finished result still waits in the output register.
module row_prefix_mean_floor_core
  import rpmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SUM_W-1:0] in_tdata,    // [31:0] sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [SUM_W-1:0] out_tdata,   // [31:0] mean
  input  logic             cfg_wr_en,
  input  logic [RW_W-1:0]  cfg_wr_data
);

  dp_cmd_t cmd;

  rpmf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rpmf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (in_tdata),
    .mean        (out_tdata)
  );

endmodule
